// ----- hw/rtl/iba_pkg.sv -----
// Shared constants, codes and control types for the id bitmap allocator.
package iba_pkg;

  localparam int MAX_IDS   = 256;
  localparam int IDX_W     = $clog2(MAX_IDS);
  localparam int CNT_W     = $clog2(MAX_IDS + 1);
  localparam int ID_W      = 16;
  localparam int RES_W     = 17;
  localparam int GRP_W     = 16;
  localparam int GRP_IDX_W = $clog2(GRP_W);
  localparam int NGRP      = (MAX_IDS + GRP_W - 1) / GRP_W;
  localparam int GSEL_W    = (NGRP > 1) ? $clog2(NGRP) : 1;
  localparam int POS_W     = GSEL_W + GRP_IDX_W;

  localparam logic [1:0] OP_ALLOC = 2'd0;
  localparam logic [1:0] OP_NEXT  = 2'd1;
  localparam logic [1:0] OP_PUT   = 2'd2;
  localparam logic [1:0] OP_TAKE  = 2'd3;

  localparam logic CFG_MIN_ID = 1'b0;
  localparam logic CFG_MAX_ID = 1'b1;

  localparam logic [ID_W-1:0] MIN_ID_RST = ID_W'(1);
  localparam logic [ID_W-1:0] MAX_ID_RST = ID_W'(256);

  typedef struct packed {
    logic load;
    logic search;
    logic pick;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic is_alloc;
  } sts_t;

endpackage

// ----- hw/rtl/iba_ifs.sv -----
// Request and response channel interfaces of the id bitmap allocator.
interface iba_req_if;
  logic                     valid;
  logic                     ready;
  logic [1:0]               op;
  logic [iba_pkg::ID_W-1:0] id_arg;

  modport source (output valid, output op, output id_arg, input ready);
  modport sink (input valid, input op, input id_arg, output ready);
endinterface

interface iba_rsp_if;
  logic                      valid;
  logic                      ready;
  logic [iba_pkg::RES_W-1:0] result_id;
  logic                      ok;

  modport source (output valid, output result_id, output ok, input ready);
  modport sink (input valid, input result_id, input ok, output ready);
endinterface

// ----- hw/rtl/iba_ctrl.sv -----
// Sequencer of the id bitmap allocator: accept, search, pick, commit.
module iba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  iba_pkg::sts_t sts,
  output iba_pkg::cmd_t cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SRCH   = 2'd1;
  localparam logic [1:0] S_PICK   = 2'd2;
  localparam logic [1:0] S_COMMIT = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       slot_free;

  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.search = 1'b0;
    cmd.pick   = 1'b0;
    cmd.commit = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = sts.is_alloc ? S_SRCH : S_COMMIT;
        end
      end
      S_SRCH: begin
        cmd.search = 1'b1;
        state_nxt  = S_PICK;
      end
      S_PICK: begin
        cmd.pick  = 1'b1;
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        // hold until the output word slot is free
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ----- hw/rtl/iba_dp.sv -----
// Datapath of the id bitmap allocator: range registers, used map and search.
module iba_dp (
  input  logic                      clk,
  input  logic                      rst_n,
  input  iba_pkg::cmd_t             cmd,
  output iba_pkg::sts_t             sts,
  input  logic [1:0]                in_op,
  input  logic [iba_pkg::ID_W-1:0]  in_id_arg,
  input  logic                      cfg_we,
  input  logic                      cfg_idx,
  input  logic [iba_pkg::ID_W-1:0]  cfg_data,
  output logic [iba_pkg::RES_W-1:0] res_id,
  output logic                      res_ok
);

  localparam int ID_W      = iba_pkg::ID_W;
  localparam int RES_W     = iba_pkg::RES_W;
  localparam int IDX_W     = iba_pkg::IDX_W;
  localparam int CNT_W     = iba_pkg::CNT_W;
  localparam int GRP_W     = iba_pkg::GRP_W;
  localparam int GRP_IDX_W = iba_pkg::GRP_IDX_W;
  localparam int NGRP      = iba_pkg::NGRP;
  localparam int GSEL_W    = iba_pkg::GSEL_W;
  localparam int POS_W     = iba_pkg::POS_W;
  localparam int MAX_IDS   = iba_pkg::MAX_IDS;

  function automatic logic [GRP_IDX_W-1:0] first_one(input logic [GRP_W-1:0] v);
    logic [GRP_IDX_W-1:0] f;
    f = '0;
    for (int j = GRP_W - 1; j >= 0; j--) begin
      if (v[j]) f = GRP_IDX_W'(j);
    end
    return f;
  endfunction

  logic [ID_W-1:0]    min_id_r, max_id_r;
  logic [MAX_IDS-1:0] used_r;
  logic [1:0]         op_r;
  logic               arg_ok_r;
  logic [CNT_W-1:0]   size_r, start_r;
  logic [IDX_W-1:0]   idx_r;
  logic               found_r;
  logic [RES_W-1:0]   res_id_r;
  logic               res_ok_r;

  // load-time range arithmetic
  logic [RES_W-1:0] rel, span, rel_inc;
  logic             below, max_lt_min;
  logic [CNT_W-1:0] size_c, start_c;
  logic             in_rng, next_ok, arg_ok_c;

  assign sts.is_alloc = (in_op == iba_pkg::OP_ALLOC) || (in_op == iba_pkg::OP_NEXT);

  always_comb begin
    rel        = RES_W'(in_id_arg) - RES_W'(min_id_r);
    below      = rel[RES_W-1];
    max_lt_min = (max_id_r < min_id_r);
    span       = RES_W'(max_id_r) - RES_W'(min_id_r) + RES_W'(1);
    if (max_lt_min) begin
      size_c = '0;
    end else if (span > RES_W'(MAX_IDS)) begin
      size_c = CNT_W'(MAX_IDS);
    end else begin
      size_c = span[CNT_W-1:0];
    end
    in_rng  = !below && (rel < RES_W'(size_c));
    next_ok = !below && (in_id_arg <= max_id_r);
    rel_inc = RES_W'(rel[ID_W-1:0]) + RES_W'(1);
    start_c = '0;
    arg_ok_c = 1'b1;
    case (in_op)
      iba_pkg::OP_ALLOC: begin
        start_c  = '0;
        arg_ok_c = 1'b1;
      end
      iba_pkg::OP_NEXT: begin
        start_c  = (rel_inc > RES_W'(MAX_IDS)) ? CNT_W'(MAX_IDS) : rel_inc[CNT_W-1:0];
        arg_ok_c = next_ok;
      end
      default: begin
        start_c  = '0;
        arg_ok_c = in_rng;
      end
    endcase
  end

  // per-group availability, masked (at or above start) and full
  logic [GRP_W-1:0]     avail_m [NGRP];
  logic [GRP_W-1:0]     avail_f [NGRP];
  logic [NGRP-1:0]      any_m_r, any_f_r;
  logic [GRP_IDX_W-1:0] first_m_r [NGRP];
  logic [GRP_IDX_W-1:0] first_f_r [NGRP];

  for (genvar g = 0; g < NGRP; g++) begin : g_grp
    for (genvar j = 0; j < GRP_W; j++) begin : g_bit
      localparam int P = g * GRP_W + j;
      if (P < MAX_IDS) begin : g_live
        assign avail_f[g][j] = !used_r[P] && (CNT_W'(P) < size_r);
        assign avail_m[g][j] = avail_f[g][j] && (CNT_W'(P) >= start_r);
      end else begin : g_pad
        assign avail_f[g][j] = 1'b0;
        assign avail_m[g][j] = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.search) begin
        any_m_r[g]   <= |avail_m[g];
        any_f_r[g]   <= |avail_f[g];
        first_m_r[g] <= first_one(avail_m[g]);
        first_f_r[g] <= first_one(avail_f[g]);
      end
    end
  end

  // group pick: lowest group with a hit, masked search first
  logic                 fm, ff;
  logic [GSEL_W-1:0]    gm, gf;
  logic [GRP_IDX_W-1:0] fmv, ffv;
  logic [POS_W-1:0]     pick_pos;

  always_comb begin
    fm  = 1'b0;
    ff  = 1'b0;
    gm  = '0;
    gf  = '0;
    fmv = '0;
    ffv = '0;
    for (int g = NGRP - 1; g >= 0; g--) begin
      if (any_m_r[g]) begin
        fm  = 1'b1;
        gm  = GSEL_W'(g);
        fmv = first_m_r[g];
      end
      if (any_f_r[g]) begin
        ff  = 1'b1;
        gf  = GSEL_W'(g);
        ffv = first_f_r[g];
      end
    end
    pick_pos = fm ? {gm, fmv} : {gf, ffv};
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r     <= in_op;
      arg_ok_r <= arg_ok_c;
      size_r   <= size_c;
      start_r  <= start_c;
      idx_r    <= rel[IDX_W-1:0];
    end else if (cmd.pick) begin
      idx_r   <= pick_pos[IDX_W-1:0];
      found_r <= fm || ff;
    end
  end

  // configuration registers and used map
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_id_r <= iba_pkg::MIN_ID_RST;
      max_id_r <= iba_pkg::MAX_ID_RST;
      used_r   <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_idx == iba_pkg::CFG_MIN_ID) begin
          min_id_r <= cfg_data;
        end else begin
          max_id_r <= cfg_data;
        end
      end
      if (cmd.commit && arg_ok_r) begin
        if ((op_r == iba_pkg::OP_ALLOC) || (op_r == iba_pkg::OP_NEXT)) begin
          if (found_r) used_r[idx_r] <= 1'b1;
        end else begin
          used_r[idx_r] <= (op_r == iba_pkg::OP_TAKE);
        end
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if ((op_r == iba_pkg::OP_ALLOC) || (op_r == iba_pkg::OP_NEXT)) begin
        if (arg_ok_r && found_r) begin
          res_id_r <= RES_W'(idx_r) + RES_W'(min_id_r);
          res_ok_r <= 1'b1;
        end else begin
          res_id_r <= RES_W'(max_id_r) + RES_W'(1);
          res_ok_r <= 1'b0;
        end
      end else begin
        res_id_r <= '0;
        res_ok_r <= arg_ok_r;
      end
    end
  end

  assign res_id = res_id_r;
  assign res_ok = res_ok_r;

endmodule

// ----- hw/rtl/id_bitmap_allocator.sv -----
// Top level of the id bitmap allocator: sequencer, datapath and channel wiring.
//
//   channel   dir   handshake      word contents
//   in_ch     in    valid/ready    op[1:0], id_arg[15:0]
//   out_ch    out   valid/ready    result_id[16:0], ok
//   cfg_*     in    cfg_we only    cfg_idx (0 min_id, 1 max_id), cfg_data[15:0]
//
// An alloc or alloc_next word passes through range setup at accept, a per-group
// find-first-free over 16-bit groups of the used map, a pick of the lowest hitting
// group, then the commit into the map and the output register. A put or take skips
// the search and the pick and goes from accept to the commit. A new word is accepted
// only once the previous one has committed; reset frees every id and loads min_id 1,
// max_id 256. Hold the commit while the output word is not yet taken.
module id_bitmap_allocator (
  input  logic                     clk,
  input  logic                     rst_n,
  iba_req_if.sink                  in_ch,
  iba_rsp_if.source                out_ch,
  input  logic                     cfg_we,
  input  logic                     cfg_idx,
  input  logic [iba_pkg::ID_W-1:0] cfg_data
);

  iba_pkg::cmd_t cmd;
  iba_pkg::sts_t sts;

  // sequencer: owns the handshakes and the output valid flag
  iba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .sts       (sts),
    .cmd       (cmd)
  );

  // datapath: range registers, used map, search tree and output word
  iba_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_ch.op),
    .in_id_arg (in_ch.id_arg),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_data  (cfg_data),
    .res_id    (out_ch.result_id),
    .res_ok    (out_ch.ok)
  );

endmodule

// ----- tb/tb.sv -----
// Self-checking testbench for the id bitmap allocator: random and directed traffic.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import iba_pkg::*;

  localparam int WORDS_PER_SET = 195;
  localparam int HOLD_CYCLES   = 300;
  localparam int RUN_LIMIT     = 400000;
  localparam int NUM_SETS      = 10;

  // One request word and one response word as the channels carry them.
  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id_arg;
  } req_word_t;

  typedef struct packed {
    logic [RES_W-1:0] result_id;
    logic             ok;
  } rsp_word_t;

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic            cfg_idx;
  logic [ID_W-1:0] cfg_data;

  iba_req_if in_ch ();
  iba_rsp_if out_ch ();

  id_bitmap_allocator u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .out_ch   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_data (cfg_data)
  );

  // Words still to be offered, and responses the allocator owes us, oldest first.
  req_word_t pending_q[$];
  rsp_word_t owed_rsp_q[$];

  // Shadow of the allocator: used bit per slot, plus the id window.
  bit              id_used [MAX_IDS];
  logic [ID_W-1:0] lo_id;
  logic [ID_W-1:0] hi_id;

  int snd_idle_pct;
  int rcv_idle_pct;
  int hold_left;
  bit hold_ask;
  bit in_took;

  int cycle_cnt;
  int n_accepted;
  int n_checked;
  int n_failed;
  int n_alloc_miss;
  int n_settings;

  // Free-running clock, 12 ns period.
  initial begin : clock_gen
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Number of usable slots: empty when the window is inverted, clamped to MAX_IDS.
  function automatic int span_size();
    int n;
    if (hi_id < lo_id) return 0;
    n = int'(hi_id) - int'(lo_id) + 1;
    return (n > MAX_IDS) ? MAX_IDS : n;
  endfunction

  // Lowest clear slot at or above from, or n when none is left.
  function automatic int first_clear(int from, int n);
    for (int i = from; i < n; i++) begin
      if (!id_used[i]) return i;
    end
    return n;
  endfunction

  // Apply one request to the shadow map and return the response it must produce.
  function automatic rsp_word_t serve_request(req_word_t w);
    rsp_word_t r;
    int n;
    int pos;
    int arg;
    int lo;
    n   = span_size();
    arg = int'(w.id_arg);
    lo  = int'(lo_id);
    r   = '0;
    if (w.op == OP_PUT || w.op == OP_TAKE) begin
      // Out-of-window ids are dropped with ok low and a zero id.
      if (arg >= lo && arg - lo < n) begin
        id_used[arg - lo] = (w.op == OP_TAKE);
        r.ok = 1'b1;
      end
      return r;
    end
    r.result_id = RES_W'(hi_id) + RES_W'(1);
    if (w.op == OP_NEXT) begin
      // A last id outside the window refuses at once.
      if (arg < lo || arg > int'(hi_id)) return r;
      pos = first_clear(arg - lo + 1, n);
      if (pos >= n) pos = first_clear(0, n);
    end else begin
      pos = first_clear(0, n);
    end
    if (pos >= n) return r;
    id_used[pos] = 1'b1;
    r.result_id = RES_W'(pos + lo);
    r.ok        = 1'b1;
    return r;
  endfunction

  // Random request: mostly ids inside the window, some on its edges, some anywhere.
  function automatic req_word_t pick_request();
    req_word_t w;
    int n;
    int roll;
    n    = span_size();
    roll = $urandom_range(99);
    if (roll < 30) w.op = OP_ALLOC;
    else if (roll < 50) w.op = OP_NEXT;
    else if (roll < 80) w.op = OP_PUT;
    else w.op = OP_TAKE;
    roll = $urandom_range(99);
    if (n > 0 && roll < 72) begin
      w.id_arg = lo_id + ID_W'($urandom_range(n - 1));
    end else if (roll < 84) begin
      case ($urandom_range(3))
        0: begin
          w.id_arg = lo_id - ID_W'(1);
        end
        1: begin
          w.id_arg = lo_id + ID_W'(n);
        end
        2: begin
          w.id_arg = hi_id;
        end
        default: begin
          w.id_arg = hi_id + ID_W'(1);
        end
      endcase
    end else begin
      w.id_arg = ID_W'($urandom);
    end
    return w;
  endfunction

  task automatic queue_req(input logic [1:0] op, input int arg);
    req_word_t w;
    w.op     = op;
    w.id_arg = ID_W'(arg);
    pending_q.push_back(w);
  endtask

  // Write one register on the next edge; the shadow follows once the edge is past.
  task automatic write_reg(input logic idx, input logic [ID_W-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MIN_ID) lo_id = val;
    else hi_id = val;
  endtask

  task automatic set_window(input int lo, input int hi);
    write_reg(CFG_MIN_ID, ID_W'(lo));
    write_reg(CFG_MAX_ID, ID_W'(hi));
    n_settings++;
  endtask

  // Hold until every word is in and every response is back, then let the pipe settle.
  task automatic drain();
    while (pending_q.size() != 0 || in_ch.valid || owed_rsp_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  // Request driver: advance to the next pending word once the current one is taken,
  // or drop valid for an idle cycle.
  always @(negedge clk) begin : drive_req
    req_word_t w;
    if (!in_ch.valid || in_took) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        w = pending_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.op     <= w.op;
        in_ch.id_arg <= w.id_arg;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Response sink: random backpressure, or a long hold-off when asked for one.
  always @(negedge clk) begin : drive_rsp_ready
    if (hold_ask) begin
      hold_ask  = 1'b0;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= rcv_idle_pct);
    end
  end

  // Predict each accepted request in acceptance order.
  always @(posedge clk) begin : watch_req
    req_word_t w;
    rsp_word_t r;
    cycle_cnt <= cycle_cnt + 1;
    in_took   <= in_ch.valid && in_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready) begin
      w.op     = in_ch.op;
      w.id_arg = in_ch.id_arg;
      r = serve_request(w);
      owed_rsp_q.push_back(r);
      n_accepted++;
      if ((w.op == OP_ALLOC || w.op == OP_NEXT) && !r.ok) n_alloc_miss++;
    end
  end

  // Check each accepted response against the oldest owed one, field by field.
  always @(posedge clk) begin : watch_rsp
    rsp_word_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (owed_rsp_q.size() == 0) begin
        n_failed++;
        $display("%0t: unexpected response, expected none actual result_id %0d ok %b",
                 $time, out_ch.result_id, out_ch.ok);
      end else begin
        want = owed_rsp_q.pop_front();
        n_checked++;
        if (out_ch.result_id !== want.result_id) begin
          n_failed++;
          $display("%0t: result_id mismatch, expected %0d actual %0d", $time,
                   want.result_id, out_ch.result_id);
        end
        if (out_ch.ok !== want.ok) begin
          n_failed++;
          $display("%0t: ok mismatch, expected %b actual %b", $time, want.ok, out_ch.ok);
        end
      end
    end
  end

  // Bound the run in cycles.
  initial begin : watchdog
    wait (cycle_cnt >= RUN_LIMIT);
    $display("id_bitmap_allocator test failed");
    $finish;
  end

  // Window settings for the random part: narrow, oversized, inverted, single slot,
  // top of the id space (failure id needs bit 16), exactly full size.
  int set_lo [NUM_SETS] = '{100, 0, 65535, 65535, 65280, 0, 40000, 5, 1, 0};
  int set_hi [NUM_SETS] = '{107, 65535, 0, 65535, 65535, 255, 40015, 4, 256, 3};

  initial begin : stimulus
    // Drive every input to a known value before the first edge.
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_idx      = CFG_MIN_ID;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.op     = OP_ALLOC;
    in_ch.id_arg = '0;
    out_ch.ready = 1'b0;
    in_took      = 1'b0;
    hold_ask     = 1'b0;
    hold_left    = 0;
    cycle_cnt    = 0;
    n_accepted   = 0;
    n_checked    = 0;
    n_failed     = 0;
    n_alloc_miss = 0;
    n_settings   = 0;
    snd_idle_pct = 25;
    rcv_idle_pct = 57;
    lo_id        = MIN_ID_RST;
    hi_id        = MAX_ID_RST;

    // Hold reset, release on a falling edge.
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed words in the reset window 1..256.
    queue_req(OP_ALLOC, 16'hFFFF);   // lowest free on an empty map
    queue_req(OP_ALLOC, 0);
    queue_req(OP_NEXT, 1);           // search just past a valid last id
    queue_req(OP_NEXT, 256);         // last id at the top wraps to the lowest
    queue_req(OP_NEXT, 0);           // last id below the window refuses
    queue_req(OP_NEXT, 257);         // last id above the window refuses
    queue_req(OP_NEXT, 65535);
    queue_req(OP_PUT, 2);            // free a held id
    queue_req(OP_PUT, 0);            // free below the window is dropped
    queue_req(OP_PUT, 257);          // free above the window is dropped
    queue_req(OP_PUT, 65535);
    queue_req(OP_TAKE, 256);         // mark the top id used
    queue_req(OP_TAKE, 0);           // take outside the window is dropped
    queue_req(OP_TAKE, 65535);
    queue_req(OP_NEXT, 255);         // top used, wraps back to the freed id
    queue_req(OP_TAKE, 5);
    queue_req(OP_NEXT, 4);           // skip a taken id
    queue_req(OP_ALLOC, 16'h5A5A);
    queue_req(OP_PUT, 1);
    queue_req(OP_ALLOC, 16'hA5A5);   // the freed lowest id comes back
    queue_req(OP_TAKE, 1);           // take of an id already held
    queue_req(OP_PUT, 256);
    queue_req(OP_NEXT, 1);
    drain();

    // Random part: one batch per window setting, map kept across settings.
    for (int p = 0; p < NUM_SETS; p++) begin
      if (p < 4) begin
        snd_idle_pct = 25;
        rcv_idle_pct = 57;
      end else if (p < 7) begin
        snd_idle_pct = 57;
        rcv_idle_pct = 25;
      end else begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end
      set_window(set_lo[p], set_hi[p]);
      repeat (WORDS_PER_SET) pending_q.push_back(pick_request());
      // On the last batch, stall the response side for a long stretch while the
      // driver keeps offering, so the allocator backs up into its input.
      if (p == NUM_SETS - 1) begin
        @(posedge clk);
        hold_ask = 1'b1;
      end
      drain();
    end

    repeat (20) @(posedge clk);
    $display("Ran %0d requests over %0d window settings; %0d responses checked.",
             n_accepted, n_settings + 1, n_checked);
    $display("Refused allocations (full, empty window or bad last id): %0d.", n_alloc_miss);
    if (n_failed == 0) begin
      $display("id_bitmap_allocator test passed");
    end else begin
      $display("id_bitmap_allocator test failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/iba_pkg.sv
hw/rtl/iba_ifs.sv
hw/rtl/iba_ctrl.sv
hw/rtl/iba_dp.sv
hw/rtl/id_bitmap_allocator.sv
tb/tb.sv
